>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the voxel extractor RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define SVX_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked at every edge, reset included.
`define SVX_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

>>> hdl/svx_pkg.sv
// ----------------------------------------------------------------------------
// svx_pkg
// Shared types and constants of the surface voxel extractor.
// ----------------------------------------------------------------------------
package svx_pkg;

    localparam int COORD_W = 5;
    localparam int OP_W    = 2;
    // A scan covers at most this many columns (x is COORD_W bits).
    localparam int SCAN_W  = 1 << COORD_W;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_SCAN   = 2'd1,
        OP_CLEAR  = 2'd2
    } op_t;

    // Surface mask of one scanned row, handed to the result serializer.
    typedef struct packed {
        logic                valid;
        logic [SCAN_W-1:0]   surf;
        logic [COORD_W-1:0]  y;
        logic [COORD_W-1:0]  z;
    } scan_load_t;

endpackage

>>> hdl/svx_cmd_if.sv
// ----------------------------------------------------------------------------
// svx_cmd_if
// Command channel: opcode and voxel / row coordinates.
// ----------------------------------------------------------------------------
interface svx_cmd_if;
    import svx_pkg::*;

    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    op;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;

    modport source (output valid, output op, output x, output y, output z, input ready);
    modport sink   (input valid, input op, input x, input y, input z, output ready);
endinterface

>>> hdl/svx_res_if.sv
// ----------------------------------------------------------------------------
// svx_res_if
// Result channel: one surface voxel, or a row-empty marker, per transfer.
// ----------------------------------------------------------------------------
interface svx_res_if;
    import svx_pkg::*;

    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] out_x;
    logic [COORD_W-1:0] out_y;
    logic [COORD_W-1:0] out_z;
    logic               found;
    logic               last;

    modport source (output valid, output out_x, output out_y, output out_z,
                    output found, output last, input ready);
    modport sink   (input valid, input out_x, input out_y, input out_z,
                    input found, input last, output ready);
endinterface

>>> hdl/svx_row_ram.sv
// ----------------------------------------------------------------------------
// svx_row_ram
// Single-port occupancy row memory, registered read data.
// ----------------------------------------------------------------------------
module svx_row_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

>>> hdl/svx_emit.sv
// ----------------------------------------------------------------------------
// svx_emit
// Serializes a row surface mask into results, lowest x first; an empty mask gives one row-empty marker.
// ----------------------------------------------------------------------------
module svx_emit (
    input  logic                clk,
    input  logic                rst_n,
    input  svx_pkg::scan_load_t load,
    output logic                busy,
    svx_res_if.source           res
);
    import svx_pkg::*;

    logic               active_reg;
    logic               none_reg;
    logic [SCAN_W-1:0]  surf_reg;
    logic [COORD_W-1:0] y_reg;
    logic [COORD_W-1:0] z_reg;
    logic               ovalid_reg;
    logic [COORD_W-1:0] ox_reg;
    logic [COORD_W-1:0] oy_reg;
    logic [COORD_W-1:0] oz_reg;
    logic               ofound_reg;
    logic               olast_reg;

    logic               advance;
    logic [SCAN_W-1:0]  lowest;
    logic [SCAN_W-1:0]  rest;
    logic [COORD_W-1:0] idx;

    // isolate lowest set bit, then one-hot to index
    assign lowest  = surf_reg & (~surf_reg + SCAN_W'(1));
    assign rest    = surf_reg & (surf_reg - SCAN_W'(1));
    assign advance = active_reg && (!ovalid_reg || res.ready);

    always_comb
    begin
        idx = '0;
        for (int i = 0; i < SCAN_W; i++)
        begin
            if (lowest[i])
            begin
                idx = idx | COORD_W'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            none_reg   <= 1'b0;
            surf_reg   <= '0;
            y_reg      <= '0;
            z_reg      <= '0;
            ovalid_reg <= 1'b0;
            ox_reg     <= '0;
            oy_reg     <= '0;
            oz_reg     <= '0;
            ofound_reg <= 1'b0;
            olast_reg  <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                ovalid_reg <= 1'b1;
                oy_reg     <= y_reg;
                oz_reg     <= z_reg;
                if (none_reg)
                begin
                    ox_reg     <= '0;
                    ofound_reg <= 1'b0;
                    olast_reg  <= 1'b1;
                    active_reg <= 1'b0;
                end
                else
                begin
                    ox_reg     <= idx;
                    ofound_reg <= 1'b1;
                    olast_reg  <= (rest == '0);
                    surf_reg   <= rest;
                    active_reg <= (rest != '0);
                end
            end
            else if (res.ready)
            begin
                ovalid_reg <= 1'b0;
            end

            // load only arrives while idle, so it never meets advance
            if (load.valid)
            begin
                active_reg <= 1'b1;
                none_reg   <= (load.surf == '0);
                surf_reg   <= load.surf;
                y_reg      <= load.y;
                z_reg      <= load.z;
            end
        end
    end

    assign busy      = active_reg;
    assign res.valid = ovalid_reg;
    assign res.out_x = ox_reg;
    assign res.out_y = oy_reg;
    assign res.out_z = oz_reg;
    assign res.found = ofound_reg;
    assign res.last  = olast_reg;
endmodule

>>> hdl/surface_voxel_extractor.sv
// ----------------------------------------------------------------------------
// surface_voxel_extractor
// Occupancy grid with insert, clear and per-row 6-neighbor surface scan.
// ----------------------------------------------------------------------------
//  channel | dir | payload                          | notes
//  --------+-----+----------------------------------+---------------------------
//  cmd     | in  | op, x, y, z                      | insert / scan / clear
//  res     | out | out_x, out_y, out_z, found, last | one surface voxel or row-empty marker a transfer
//
//  Insert: read the row word, then write it back with the bit set (S_INS_WR).
//  Scan: the centre row read goes out in the accept cycle and the four neighbor
//  row reads in the S_SCAN steps; the last read lands, then S_LOAD hands the mask
//  to the serializer (held while it is busy). Results leave one a cycle while res
//  is ready; commands are taken while they drain. Clear: one row word zeroed a
//  cycle over the whole grid; after reset the same sweep runs with cmd.ready low.
//  A stalled res holds its output register; only the next mask handover waits.
// ----------------------------------------------------------------------------
module surface_voxel_extractor #(
    parameter int GRID_DIM = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    svx_cmd_if.sink   cmd,
    svx_res_if.source res
);
    import svx_pkg::*;

    localparam int NUM_ROWS = GRID_DIM * GRID_DIM;
    localparam int ADDR_W   = $clog2(NUM_ROWS);
    // columns that can ever be occupied
    localparam int ROW_W    = (GRID_DIM < SCAN_W) ? GRID_DIM : SCAN_W;
    localparam int LAST_RD  = 5;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_INS_WR,
        S_SCAN,
        S_LOAD
    } state_t;

    state_t             state_reg;
    logic [2:0]         step_reg;     // scan: row read issued this cycle
    logic               rd_ok_reg;    // last issued read lies inside the grid
    logic [ADDR_W-1:0]  addr_reg;
    logic [ADDR_W-1:0]  clr_addr_reg;
    logic [COORD_W-1:0] x_reg;
    logic [COORD_W-1:0] y_reg;
    logic [COORD_W-1:0] z_reg;
    logic [ROW_W-1:0]   center_reg;
    logic [ROW_W-1:0]   nbr_reg;      // AND of the four neighbor rows

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_addr;
    logic [ROW_W-1:0]   ram_wdata;
    logic [ROW_W-1:0]   ram_rdata;
    logic [ROW_W-1:0]   rd_data;

    logic [COORD_W:0]   ny;
    logic [COORD_W:0]   nz;
    logic               nb_ok;
    logic               cmd_in_grid;
    logic               cmd_xfer;
    logic [ROW_W-1:0]   enclosed;
    logic [ROW_W-1:0]   surf;
    scan_load_t         load;
    logic               emit_busy;

    function automatic logic [ADDR_W-1:0] row_addr(input logic [COORD_W:0] yy,
                                                   input logic [COORD_W:0] zz);
        return ADDR_W'(int'(yy) * GRID_DIM + int'(zz));
    endfunction

    assign cmd.ready   = (state_reg == S_IDLE);
    assign cmd_xfer    = cmd.valid && cmd.ready;
    assign cmd_in_grid = (int'(cmd.y) < GRID_DIM) && (int'(cmd.z) < GRID_DIM);
    assign rd_data     = rd_ok_reg ? ram_rdata : '0;

    // neighbor row for the read issued at this scan step
    always_comb
    begin
        ny    = {1'b0, y_reg};
        nz    = {1'b0, z_reg};
        nb_ok = 1'b1;
        case (step_reg)
            3'd1:
            begin
                ny    = {1'b0, y_reg} - 1'b1;
                nb_ok = (y_reg != '0);
            end
            3'd2: ny = {1'b0, y_reg} + 1'b1;
            3'd3:
            begin
                nz    = {1'b0, z_reg} - 1'b1;
                nb_ok = (z_reg != '0);
            end
            3'd4: nz = {1'b0, z_reg} + 1'b1;
            default: ;
        endcase
        nb_ok = nb_ok && (int'(ny) < GRID_DIM) && (int'(nz) < GRID_DIM);
    end

    // RAM port steering
    always_comb
    begin
        ram_we    = 1'b0;
        ram_wdata = '0;
        ram_addr  = row_addr({1'b0, cmd.y}, {1'b0, cmd.z});
        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we   = 1'b1;
                ram_addr = clr_addr_reg;
            end
            S_INS_WR:
            begin
                ram_we    = rd_ok_reg;
                ram_addr  = addr_reg;
                ram_wdata = ram_rdata | (ROW_W'(1) << x_reg);
            end
            S_SCAN:   ram_addr = row_addr(ny, nz);
            S_IDLE:   ;
            S_LOAD:   ;
            default:  ;
        endcase
    end

    assign enclosed = center_reg & (center_reg << 1) & (center_reg >> 1) & nbr_reg;
    assign surf     = center_reg & ~enclosed;

    always_comb
    begin
        load.valid = (state_reg == S_LOAD) && !emit_busy;
        load.surf  = SCAN_W'(surf);
        load.y     = y_reg;
        load.z     = z_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            step_reg     <= '0;
            rd_ok_reg    <= 1'b0;
            addr_reg     <= '0;
            clr_addr_reg <= '0;
            x_reg        <= '0;
            y_reg        <= '0;
            z_reg        <= '0;
            center_reg   <= '0;
            nbr_reg      <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                    if (clr_addr_reg == ADDR_W'(NUM_ROWS - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (cmd_xfer)
                    begin
                        x_reg    <= cmd.x;
                        y_reg    <= cmd.y;
                        z_reg    <= cmd.z;
                        addr_reg <= ram_addr;
                        step_reg <= 3'd1;
                        nbr_reg  <= '1;
                        case (cmd.op)
                            OP_INSERT:
                            begin
                                rd_ok_reg <= cmd_in_grid && (int'(cmd.x) < GRID_DIM);
                                state_reg <= S_INS_WR;
                            end
                            OP_SCAN:
                            begin
                                rd_ok_reg <= cmd_in_grid;
                                state_reg <= S_SCAN;
                            end
                            OP_CLEAR:
                            begin
                                clr_addr_reg <= '0;
                                state_reg    <= S_CLEAR;
                            end
                            default: ;   // unused opcode: dropped
                        endcase
                    end
                end
                S_INS_WR:
                begin
                    state_reg <= S_IDLE;
                end
                S_SCAN:
                begin
                    // consume the read issued last cycle
                    if (step_reg == 3'd1)
                    begin
                        center_reg <= rd_data;
                    end
                    else
                    begin
                        nbr_reg <= nbr_reg & rd_data;
                    end
                    rd_ok_reg <= nb_ok;
                    step_reg  <= step_reg + 1'b1;
                    if (step_reg == 3'(LAST_RD))
                    begin
                        state_reg <= S_LOAD;
                    end
                end
                S_LOAD:
                begin
                    if (!emit_busy)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    svx_row_ram #(
        .DEPTH (NUM_ROWS),
        .WIDTH (ROW_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    svx_emit u_emit (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (load),
        .busy  (emit_busy),
        .res   (res)
    );

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
`include "assert_macros.svh"

    `SVX_ASSERT_ALWAYS(a_no_cmd_in_reset, !rst_n |-> !cmd.ready, "cmd ready during reset")
    `SVX_ASSERT(a_scan_step_range,
                state_reg == S_SCAN |-> step_reg >= 3'd1 && step_reg <= 3'(LAST_RD),
                "scan step out of range")
    `SVX_ASSERT(a_empty_is_last,
                res.valid && !res.found |-> res.last,
                "empty-row result not marked last")
    `SVX_ASSERT(a_insert_writes,
                cmd_xfer && cmd.op == OP_INSERT |=> state_reg == S_INS_WR,
                "insert did not reach write-back")

endmodule
